>>> sv/pks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types, state codes, register indexes and reset values for the power
// key sequencer.
// ----------------------------------------------------------------------------
package pks_pkg;

    // field widths fixed by the beat layout
    localparam int NOW_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CNT_W    = 16;
    localparam int STATE_W  = 3;
    localparam int CADDR_W  = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // power machine states
    localparam logic [STATE_W-1:0] ST_INIT     = 3'd0;
    localparam logic [STATE_W-1:0] ST_ON       = 3'd1;
    localparam logic [STATE_W-1:0] ST_WAIT_OFF = 3'd2;
    localparam logic [STATE_W-1:0] ST_OFF      = 3'd3;
    localparam logic [STATE_W-1:0] ST_CHARGE   = 3'd4;

    // configuration register indexes
    localparam logic [CADDR_W-1:0] REG_QUERY_SET    = 3'd0;
    localparam logic [CADDR_W-1:0] REG_LONG_HOLD    = 3'd1;
    localparam logic [CADDR_W-1:0] REG_BOOT_RELEASE = 3'd2;
    localparam logic [CADDR_W-1:0] REG_HOLD_CUT     = 3'd3;
    localparam logic [CADDR_W-1:0] REG_RESTART_HOLD = 3'd4;
    localparam logic [CADDR_W-1:0] REG_OFF_RELEASE  = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0] RST_QUERY_SET    = 16'd10;
    localparam logic [CFG_W-1:0] RST_LONG_HOLD    = 16'd100;
    localparam logic [CFG_W-1:0] RST_BOOT_RELEASE = 16'd80;
    localparam logic [CFG_W-1:0] RST_HOLD_CUT     = 16'd1;
    localparam logic [CFG_W-1:0] RST_RESTART_HOLD = 16'd150;
    localparam logic [CFG_W-1:0] RST_OFF_RELEASE  = 16'd5000;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [CFG_W-1:0] query_set_ticks;
        logic [CFG_W-1:0] long_hold_ticks;
        logic [CFG_W-1:0] boot_release_ticks;
        logic [CFG_W-1:0] hold_cut_ticks;
        logic [CFG_W-1:0] restart_hold_ticks;
        logic [CFG_W-1:0] off_release_polls;
    } t_cfg;

    typedef struct packed {
        logic [NOW_W-1:0] now_tick;
        logic             key_level;
        logic             charge_level;
        logic             query_read;
        logic             force_on;
    } t_item;

    typedef struct packed {
        logic               charge_event;
        logic               press_event;
        logic               off_event;
        logic               on_event;
        logic               query_taken;
        logic               key_query;
        logic               off_side;
        logic [STATE_W-1:0] power_state;
        logic               power_hold;
    } t_result;

endpackage

>>> sv/pks_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_cfg_regs
// Configuration register file; one write per accepted beat, unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module pks_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [pks_pkg::CADDR_W-1:0] i_wr_addr,
    input  logic [pks_pkg::CFG_W-1:0]   i_wr_data,
    output pks_pkg::t_cfg               o_cfg
);

    pks_pkg::t_cfg r_cfg;

    // register writes, reset to the power-on limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.query_set_ticks    <= pks_pkg::RST_QUERY_SET;
            r_cfg.long_hold_ticks    <= pks_pkg::RST_LONG_HOLD;
            r_cfg.boot_release_ticks <= pks_pkg::RST_BOOT_RELEASE;
            r_cfg.hold_cut_ticks     <= pks_pkg::RST_HOLD_CUT;
            r_cfg.restart_hold_ticks <= pks_pkg::RST_RESTART_HOLD;
            r_cfg.off_release_polls  <= pks_pkg::RST_OFF_RELEASE;
        end else if (i_wr_en) begin
            case (i_wr_addr)
                pks_pkg::REG_QUERY_SET:    r_cfg.query_set_ticks    <= i_wr_data;
                pks_pkg::REG_LONG_HOLD:    r_cfg.long_hold_ticks    <= i_wr_data;
                pks_pkg::REG_BOOT_RELEASE: r_cfg.boot_release_ticks <= i_wr_data;
                pks_pkg::REG_HOLD_CUT:     r_cfg.hold_cut_ticks     <= i_wr_data;
                pks_pkg::REG_RESTART_HOLD: r_cfg.restart_hold_ticks <= i_wr_data;
                pks_pkg::REG_OFF_RELEASE:  r_cfg.off_release_polls  <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/pks_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_core
// Poll step logic: key stamps, released-poll counter, query flag, press arm
// and the five-state power machine. State advances once per stepped poll.
// ----------------------------------------------------------------------------
module pks_core #(
    parameter int TICK_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  pks_pkg::t_item    i_item,
    input  pks_pkg::t_cfg     i_cfg,
    output pks_pkg::t_result  o_result
);

    logic [pks_pkg::STATE_W-1:0] r_state, n_state;
    logic [TICK_WIDTH-1:0]       r_act_stamp, n_act_stamp;
    logic [TICK_WIDTH-1:0]       r_idle_stamp, n_idle_stamp;
    logic [pks_pkg::CNT_W-1:0]   r_idle_cnt, n_idle_cnt;
    logic                        r_query, n_query;
    logic                        r_armed, n_armed;
    logic                        r_prev_act;
    logic                        r_hold, n_hold;

    logic                  active, charging;
    logic [TICK_WIDTH-1:0] now;
    logic [TICK_WIDTH-1:0] since_act, since_idle;
    logic [TICK_WIDTH-1:0] lim_query, lim_long, lim_boot, lim_cut, lim_restart;
    logic                  taken, ev_on, ev_off, ev_press, ev_chg;

    assign now         = TICK_WIDTH'(i_item.now_tick);
    assign active      = !i_item.key_level;
    assign charging    = !i_item.charge_level;
    assign lim_query   = TICK_WIDTH'(i_cfg.query_set_ticks);
    assign lim_long    = TICK_WIDTH'(i_cfg.long_hold_ticks);
    assign lim_boot    = TICK_WIDTH'(i_cfg.boot_release_ticks);
    assign lim_cut     = TICK_WIDTH'(i_cfg.hold_cut_ticks);
    assign lim_restart = TICK_WIDTH'(i_cfg.restart_hold_ticks);

    // stamps after this poll's key sample; wrap-around differences to now
    always_comb begin
        n_act_stamp = active ? now : r_act_stamp;
        since_act   = now - n_act_stamp;
        since_idle  = now - (active ? r_idle_stamp : now);
    end

    // one poll step
    always_comb begin
        n_state      = r_state;
        n_hold       = r_hold;
        n_armed      = r_armed;
        n_query      = r_query;
        n_idle_stamp = active ? r_idle_stamp : now;
        taken        = 1'b0;
        ev_on        = 1'b0;
        ev_off       = 1'b0;
        ev_press     = 1'b0;
        ev_chg       = 1'b0;

        if (active) begin
            n_idle_cnt = '0;
        end else if (r_idle_cnt != pks_pkg::CNT_MAX) begin
            n_idle_cnt = r_idle_cnt + 1'b1;
        end else begin
            n_idle_cnt = r_idle_cnt;
        end

        // read-and-clear, then forced power-on
        if (i_item.query_read) begin
            taken   = r_query;
            n_query = 1'b0;
        end
        if (i_item.force_on) begin
            n_state = pks_pkg::ST_WAIT_OFF;
            n_hold  = 1'b1;
            ev_on   = 1'b1;
        end

        // query flag: set on release time, cleared on long hold
        if (since_act > lim_query) n_query = 1'b1;
        if (since_idle > lim_long) n_query = 1'b0;

        case (n_state)
            pks_pkg::ST_INIT: begin
                if (since_act > lim_boot) begin
                    n_state = pks_pkg::ST_ON;
                    ev_on   = 1'b1;
                end
                if (since_idle > lim_cut) n_hold = 1'b0;
                // charge check wins over the boot transition
                if (charging && since_idle > lim_long) begin
                    n_state = pks_pkg::ST_CHARGE;
                    ev_chg  = 1'b1;
                end
            end
            pks_pkg::ST_ON: begin
                n_hold = 1'b1;
                if (!r_prev_act && active) n_state = pks_pkg::ST_WAIT_OFF;
            end
            pks_pkg::ST_WAIT_OFF: begin
                if (since_act > lim_long && n_idle_cnt > i_cfg.off_release_polls) begin
                    n_state    = pks_pkg::ST_OFF;
                    ev_off     = 1'b1;
                    n_idle_cnt = '0;
                end else if (!n_armed && since_act > lim_query) begin
                    n_armed = 1'b1;
                end
                if (n_armed && since_idle > lim_query) begin
                    ev_press = 1'b1;
                    n_armed  = 1'b0;
                end
                if (charging) begin
                    n_state = pks_pkg::ST_CHARGE;
                    ev_chg  = 1'b1;
                end
            end
            pks_pkg::ST_OFF: begin
                if (since_idle > lim_restart) begin
                    n_hold       = 1'b0;
                    n_idle_stamp = now;
                    n_state      = pks_pkg::ST_INIT;
                end
            end
            pks_pkg::ST_CHARGE: begin
                if (!charging) n_state = pks_pkg::ST_INIT;
            end
            default: ;
        endcase
    end

    // state update per stepped poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pks_pkg::ST_INIT;
            r_act_stamp  <= '0;
            r_idle_stamp <= '0;
            r_idle_cnt   <= '0;
            r_query      <= 1'b0;
            r_armed      <= 1'b0;
            r_prev_act   <= 1'b0;
            r_hold       <= 1'b1;
        end else if (i_step) begin
            r_state      <= n_state;
            r_act_stamp  <= n_act_stamp;
            r_idle_stamp <= n_idle_stamp;
            r_idle_cnt   <= n_idle_cnt;
            r_query      <= n_query;
            r_armed      <= n_armed;
            r_prev_act   <= active;
            r_hold       <= n_hold;
        end
    end

    // result of this poll
    always_comb begin
        o_result.power_hold   = n_hold;
        o_result.power_state  = n_state;
        o_result.off_side     = (n_state == pks_pkg::ST_WAIT_OFF) ||
                                (n_state == pks_pkg::ST_OFF);
        o_result.key_query    = n_query;
        o_result.query_taken  = taken;
        o_result.on_event     = ev_on;
        o_result.off_event    = ev_off;
        o_result.press_event  = ev_press;
        o_result.charge_event = ev_chg;
    end

endmodule

>>> sv/power_key_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_key_sequencer
// Power key and charge pin sequencer: one poll beat in, one status beat out.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+-------------------------------
//  s (poll)  | in  | i_s_tvalid/o_s_tready | i_s_tdata  40b
//  m (status)| out | o_m_tvalid/i_m_tready | o_m_tdata  16b
//  cfg       | in  | i_cfg_valid/o_cfg_ready| i_cfg_addr 3b, i_cfg_data 16b
//
// One poll per cycle sustained while status beats are taken. An accepted
// poll waits in the input register, the step logic updates state and loads
// the result register, which then presents the status beat.
// Synchronous active-low reset empties both registers and restores the limits.
// A stalled status beat holds; the input register still takes one more poll.
// Configuration writes are always accepted and take effect on the next cycle.
// ----------------------------------------------------------------------------
module power_key_sequencer #(
    parameter int TICK_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // poll beats
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [31:0] now_tick, [32] key_level, [33] charge_level, [34] query_read,
    // [35] force_on, [39:36] zero
    input  logic [pks_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // status beats
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] power_hold, [3:1] power_state, [4] off_side, [5] key_query,
    // [6] query_taken, [7] on_event, [8] off_event, [9] press_event,
    // [10] charge_event, [15:11] zero
    output logic [pks_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pks_pkg::CADDR_W-1:0]     i_cfg_addr,
    input  logic [pks_pkg::CFG_W-1:0]       i_cfg_data
);

    pks_pkg::t_cfg    cfg;
    pks_pkg::t_item   r_item;
    pks_pkg::t_result step_res, r_res;
    logic             r_in_valid, r_out_valid;
    logic             out_load, step;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    pks_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_valid),
        .i_wr_addr (i_cfg_addr),
        .i_wr_data (i_cfg_data),
        .o_cfg     (cfg)
    );

    // handshake: result register frees up when empty or taken
    assign out_load   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_load;
    assign o_s_tready = !r_in_valid || out_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.now_tick     <= i_s_tdata[pks_pkg::NOW_W-1:0];
            r_item.key_level    <= i_s_tdata[pks_pkg::NOW_W];
            r_item.charge_level <= i_s_tdata[pks_pkg::NOW_W+1];
            r_item.query_read   <= i_s_tdata[pks_pkg::NOW_W+2];
            r_item.force_on     <= i_s_tdata[pks_pkg::NOW_W+3];
        end
    end

    pks_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(pks_pkg::OUT_TDATA_W - $bits(pks_pkg::t_result)){1'b0}}, r_res};

endmodule

>>> sv/pks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_checker
// Port-level checks on the status channel of the power key sequencer.
// ----------------------------------------------------------------------------
module pks_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [pks_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic [pks_pkg::STATE_W-1:0] st;
    assign st = o_m_tdata[3:1];

    // no status beat right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("status beat valid after reset");

    // stalled beat holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled status beat changed");

    // off_side follows the reported state
    a_off_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[4] ==
            ((st == pks_pkg::ST_WAIT_OFF) || (st == pks_pkg::ST_OFF)))
        else $error("off_side disagrees with power_state");

    // charge entry always lands in the charge state
    a_charge_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10] |-> st == pks_pkg::ST_CHARGE)
        else $error("charge event without charge state");

    // power-off lands in off unless a charge check overrides it
    a_off_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |->
            (st == pks_pkg::ST_OFF) || (st == pks_pkg::ST_CHARGE && o_m_tdata[10]))
        else $error("off event with wrong state");

endmodule

bind power_key_sequencer pks_checker u_pks_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for power_key_sequencer: key/charge poll beats in, one
// status beat out per poll. A behavioral copy of the power machine in the
// status board predicts every status beat and each one is checked in order.
// Stimulus runs a short directed sequence, then phases of random polls with
// key runs, charge runs and tick noise under changing limits, then a long
// released run that carries the released-poll counter past the off limit.
// Random bursts and gaps on the poll side, a stall pattern on the status side.
// ----------------------------------------------------------------------------
module tb;
    import pks_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int IDLE_POLLS   = 60;
    localparam int PHASE_POLLS  = 110;
    // indexes past the register file, writes there must do nothing
    localparam logic [CADDR_W-1:0] REG_HOLE_LO = 3'd6;
    localparam logic [CADDR_W-1:0] REG_HOLE_HI = 3'd7;

    // ------------------------------------------------------------------------
    // Status board: behavioral power machine plus queue of expected statuses
    // ------------------------------------------------------------------------
    class power_status_board;
        t_cfg               limits;
        logic [STATE_W-1:0] mode;
        logic [NOW_W-1:0]   active_stamp;
        logic [NOW_W-1:0]   idle_stamp;
        logic [CNT_W-1:0]   idle_polls;
        logic               query_flag;
        logic               press_armed;
        logic               key_was_active;
        logic               hold;
        t_result            pending[$];
        int                 polls;
        int                 statuses;
        int                 failures;
        int                 n_on, n_off, n_press, n_charge;
        bit [7:0]           states_seen;

        function new();
            limits = '{RST_QUERY_SET, RST_LONG_HOLD, RST_BOOT_RELEASE,
                       RST_HOLD_CUT, RST_RESTART_HOLD, RST_OFF_RELEASE};
            mode           = ST_INIT;
            active_stamp   = '0;
            idle_stamp     = '0;
            idle_polls     = '0;
            query_flag     = 1'b0;
            press_armed    = 1'b0;
            key_was_active = 1'b0;
            hold           = 1'b1;
        endfunction

        function void write_reg(logic [CADDR_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_QUERY_SET:    limits.query_set_ticks    = val;
                REG_LONG_HOLD:    limits.long_hold_ticks    = val;
                REG_BOOT_RELEASE: limits.boot_release_ticks = val;
                REG_HOLD_CUT:     limits.hold_cut_ticks     = val;
                REG_RESTART_HOLD: limits.restart_hold_ticks = val;
                REG_OFF_RELEASE:  limits.off_release_polls  = val;
                default: ;
            endcase
        endfunction

        // one poll through the power machine
        function t_result step_poll(t_item it);
            t_result          r;
            logic             active;
            logic             charging;
            logic [NOW_W-1:0] held_for;
            logic [NOW_W-1:0] released_for;
            r        = '0;
            active   = ~it.key_level;
            charging = ~it.charge_level;

            // commands act before the step
            if (it.query_read) begin
                r.query_taken = query_flag;
                query_flag    = 1'b0;
            end
            if (it.force_on) begin
                mode       = ST_WAIT_OFF;
                hold       = 1'b1;
                r.on_event = 1'b1;
            end

            if (active) begin
                active_stamp = it.now_tick;
                idle_polls   = '0;
            end else begin
                idle_stamp = it.now_tick;
                if (idle_polls != CNT_MAX)
                    idle_polls++;
            end
            // wrapping tick distances
            held_for     = it.now_tick - active_stamp;
            released_for = it.now_tick - idle_stamp;

            if (held_for > limits.query_set_ticks)
                query_flag = 1'b1;
            if (released_for > limits.long_hold_ticks)
                query_flag = 1'b0;

            case (mode)
                ST_INIT: begin
                    if (held_for > limits.boot_release_ticks) begin
                        mode       = ST_ON;
                        r.on_event = 1'b1;
                    end
                    if (released_for > limits.hold_cut_ticks)
                        hold = 1'b0;
                    // late charge check wins over the move to on
                    if (charging && released_for > limits.long_hold_ticks) begin
                        mode           = ST_CHARGE;
                        r.charge_event = 1'b1;
                    end
                end
                ST_ON: begin
                    hold = 1'b1;
                    if (!key_was_active && active)
                        mode = ST_WAIT_OFF;
                end
                ST_WAIT_OFF: begin
                    if (held_for > limits.long_hold_ticks &&
                        idle_polls > limits.off_release_polls) begin
                        mode        = ST_OFF;
                        r.off_event = 1'b1;
                        idle_polls  = '0;
                    end else if (!press_armed && held_for > limits.query_set_ticks) begin
                        press_armed = 1'b1;
                    end
                    if (press_armed && released_for > limits.query_set_ticks) begin
                        r.press_event = 1'b1;
                        press_armed   = 1'b0;
                    end
                    if (charging) begin
                        mode           = ST_CHARGE;
                        r.charge_event = 1'b1;
                    end
                end
                ST_OFF: begin
                    if (released_for > limits.restart_hold_ticks) begin
                        hold       = 1'b0;
                        idle_stamp = it.now_tick;
                        mode       = ST_INIT;
                    end
                end
                ST_CHARGE: begin
                    if (!charging)
                        mode = ST_INIT;
                end
                default: ;
            endcase
            key_was_active = active;

            r.power_hold  = hold;
            r.power_state = mode;
            r.off_side    = (mode == ST_WAIT_OFF || mode == ST_OFF);
            r.key_query   = query_flag;
            return r;
        endfunction

        function void take_poll(t_item it);
            pending.push_back(step_poll(it));
            polls++;
        endfunction

        function void check_status(logic [OUT_TDATA_W-1:0] beat);
            t_result want;
            t_result got;
            logic [4:0] pad;
            got = beat[10:0];
            pad = beat[15:11];
            statuses++;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("status beat %h with no poll outstanding", beat);
                return;
            end
            want = pending.pop_front();
            if (got.power_hold !== want.power_hold || got.power_state !== want.power_state ||
                got.off_side !== want.off_side || got.key_query !== want.key_query ||
                got.query_taken !== want.query_taken || got.on_event !== want.on_event ||
                got.off_event !== want.off_event || got.press_event !== want.press_event ||
                got.charge_event !== want.charge_event || pad !== 5'b00000) begin
                failures++;
                if (failures <= 10) begin
                    $display("status %0d: want hold=%b st=%0d off=%b q=%b tk=%b ev=%b%b%b%b",
                             statuses, want.power_hold, want.power_state, want.off_side,
                             want.key_query, want.query_taken, want.on_event,
                             want.off_event, want.press_event, want.charge_event);
                    $display("status %0d:  got hold=%b st=%0d off=%b q=%b tk=%b ev=%b%b%b%b pad=%b",
                             statuses, got.power_hold, got.power_state, got.off_side,
                             got.key_query, got.query_taken, got.on_event,
                             got.off_event, got.press_event, got.charge_event, pad);
                end
            end
            if (got.on_event)     n_on++;
            if (got.off_event)    n_off++;
            if (got.press_event)  n_press++;
            if (got.charge_event) n_charge++;
            states_seen[got.power_state] = 1'b1;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its ports
    // ------------------------------------------------------------------------
    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata  = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CADDR_W-1:0]      i_cfg_addr  = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;

    power_key_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    power_status_board board = new();

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d statuses outstanding",
                     cycles, board.pending.size());
            $display("[power_key_sequencer] ERROR");
            $finish;
        end
    end

    // status side stall pattern: modes of always, mostly and rarely ready,
    // and a capped stall run counter forces ready
    int  stall_mode = 0;
    int  mode_left  = 0;
    int  stall_run  = 0;
    logic take_next;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       take_next = 1'b1;
            1:       take_next = ($urandom_range(0, 3) != 0);
            default: take_next = ($urandom_range(0, 3) == 0);
        endcase
        if (stall_run >= 7)
            take_next = 1'b1;
        stall_run = take_next ? 0 : stall_run + 1;
        i_m_tready <= take_next;
    end

    // status beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_status(o_m_tdata);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    logic [NOW_W-1:0] tick_now  = '0;
    logic             key_lvl   = 1'b1;
    logic             chg_lvl   = 1'b1;
    int               run_left  = 0;
    int               burst_left = 0;

    task automatic send_poll(input t_item it);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, it.force_on, it.query_read, it.charge_level,
                       it.key_level, it.now_tick};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        board.take_poll(it);
    endtask

    function automatic t_item mk_poll(logic [NOW_W-1:0] tick, logic key, logic chg,
                                      logic rd, logic frc);
        t_item it;
        it.now_tick     = tick;
        it.key_level    = key;
        it.charge_level = chg;
        it.query_read   = rd;
        it.force_on     = frc;
        return it;
    endfunction

    task automatic write_reg(input logic [CADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.write_reg(idx, val);
    endtask

    task automatic set_limits(input t_cfg c);
        write_reg(REG_QUERY_SET,    c.query_set_ticks);
        write_reg(REG_LONG_HOLD,    c.long_hold_ticks);
        write_reg(REG_BOOT_RELEASE, c.boot_release_ticks);
        write_reg(REG_HOLD_CUT,     c.hold_cut_ticks);
        write_reg(REG_RESTART_HOLD, c.restart_hold_ticks);
        write_reg(REG_OFF_RELEASE,  c.off_release_polls);
        write_reg(REG_HOLE_LO,      16'($urandom));
        write_reg(REG_HOLE_HI,      16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg pick_limits(int top, int polls_top);
        t_cfg c;
        c.query_set_ticks    = 16'($urandom_range(0, top));
        c.long_hold_ticks    = 16'($urandom_range(0, top));
        c.boot_release_ticks = 16'($urandom_range(0, top));
        c.hold_cut_ticks     = 16'($urandom_range(0, top));
        c.restart_hold_ticks = 16'($urandom_range(0, top));
        c.off_release_polls  = 16'($urandom_range(0, polls_top));
        return c;
    endfunction

    // stop polling until every status is back, then let the pipe settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // bursts of back-to-back polls with random gaps between them
    task automatic pace(input int max_gap);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // key held and released runs, occasional charge runs, some noise polls
    task automatic run_random(input int count, input int step_top, input int max_gap);
        t_item it;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                key_lvl  = $urandom_range(0, 1);
                chg_lvl  = ($urandom_range(0, 5) != 0);
                run_left = $urandom_range(1, 30);
            end
            run_left--;
            tick_now += $urandom_range(0, step_top);
            it = mk_poll(tick_now, key_lvl, chg_lvl, $urandom_range(0, 3) == 0,
                         $urandom_range(0, 39) == 0);
            if ($urandom_range(0, 11) == 0) begin
                it = {$urandom, 4'($urandom_range(0, 15))};
                if ($urandom_range(0, 1) == 1)
                    tick_now = it.now_tick;
            end
            pace(max_gap);
            send_poll(it);
        end
    endtask

    // park in charge with the key released long enough to run the released
    // count past the off limit, then force wait-off: power-off needs that count
    task automatic run_long_release();
        t_cfg c;
        c = pick_limits(30, 10);
        c.long_hold_ticks   = '0;
        c.off_release_polls = 16'd40;
        drain();
        set_limits(c);
        tick_now++;
        send_poll(mk_poll(tick_now, 1'b1, 1'b0, 1'b0, 1'b1));
        for (int n = 0; n < IDLE_POLLS; n++) begin
            tick_now++;
            send_poll(mk_poll(tick_now, 1'b1, 1'b0, $urandom_range(0, 3) == 0, 1'b0));
        end
        tick_now++;
        send_poll(mk_poll(tick_now, 1'b1, 1'b1, 1'b0, 1'b0));
        tick_now++;
        send_poll(mk_poll(tick_now, 1'b1, 1'b1, 1'b0, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cfg c;
        int   step_top;
        int   max_gap;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk under reset limits: charge from init, charge exit,
        // boot to on, query read, on to wait-off, press arm and fire,
        // force with read, charge from wait-off, tick wrap
        send_poll(mk_poll(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_0005, 1'b0, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_00C8, 1'b0, 1'b0, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_00C9, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_012C, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_012D, 1'b1, 1'b1, 1'b1, 1'b0));
        send_poll(mk_poll(32'h0000_012E, 1'b0, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_0140, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_0154, 1'b0, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_0159, 1'b0, 1'b1, 1'b1, 1'b1));
        send_poll(mk_poll(32'h0000_015A, 1'b1, 1'b0, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_015B, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0));
        send_poll(mk_poll(32'h0000_0008, 1'b1, 1'b1, 1'b1, 1'b0));
        send_poll(mk_poll(32'h0000_0100, 1'b1, 1'b1, 1'b0, 1'b1));
        send_poll(mk_poll(32'h0000_0101, 1'b0, 1'b0, 1'b1, 1'b0));
        send_poll(mk_poll(32'h5555_AAAA, 1'b1, 1'b0, 1'b1, 1'b1));
        send_poll(mk_poll(32'hAAAA_5555, 1'b0, 1'b1, 1'b0, 1'b0));
        tick_now = 32'h0000_1000;

        // random phases, limits change only with the pipe empty
        for (int p = 0; p < 6; p++) begin
            case (p)
                1: begin c = '0;                 step_top = 3;     max_gap = 0; end
                2: begin c = pick_limits(40, 20); step_top = 8;    max_gap = 6; end
                3: begin c = '1;                 step_top = 20000; max_gap = 3; end
                4: begin c = pick_limits(25, 10); step_top = 5;    max_gap = 4; end
                5: begin c = pick_limits(60, 30); step_top = 12;   max_gap = 2; end
                default: begin c = pick_limits(40, 20); step_top = 8; max_gap = 4; end
            endcase
            if (p == 4)
                tick_now = 32'hFFFF_FE00;
            drain();
            set_limits(c);
            run_random(PHASE_POLLS, step_top, max_gap);
        end

        run_long_release();

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d polls, %0d status beats, seven limit settings incl. all-zero,",
                 board.polls, board.statuses);
        $display("all-ones and a long release; on/off/press/charge %0d/%0d/%0d/%0d, states %b",
                 board.n_on, board.n_off, board.n_press, board.n_charge, board.states_seen[4:0]);
        if (board.failures == 0 && board.pending.size() == 0) begin
            $display("[power_key_sequencer] OK");
        end else begin
            $display("%0d mismatches, %0d statuses missing", board.failures,
                     board.pending.size());
            $display("[power_key_sequencer] ERROR");
        end
        $finish;
    end

endmodule

>>> power_key_sequencer.f
sv/pks_pkg.sv
sv/pks_cfg_regs.sv
sv/pks_core.sv
sv/power_key_sequencer.sv
sv/pks_checker.sv
tb/tb.sv
